[rtl/lds_pkg.sv]
// shared types, constants and helpers for the led driver chain serializer
package lds_pkg;

  localparam int unsigned MaxChips    = 4;
  localparam int unsigned RowSlots    = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PacketW     = 2 * ByteW;
  localparam int unsigned BitCntW     = $clog2(PacketW);
  localparam int unsigned ChipIdxW    = 2;
  localparam int unsigned CountW      = 3;
  localparam int unsigned FuncW       = 2;
  localparam logic [ByteW-1:0] NoopByte = 8'h00;

  typedef enum logic [FuncW-1:0] {
    FuncSingle = 2'd0,
    FuncBcast  = 2'd1,
    FuncRow    = 2'd2
  } func_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StShift = 1'b1
  } state_e;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [RowSlots-1:0] rows_t;

  // sequencer to shifter
  typedef struct packed {
    logic               load;
    logic               shift;
    logic [PacketW-1:0] packet;
  } shift_ctrl_t;

  // sequencer status toward the output port
  typedef struct packed {
    logic busy;
    logic last_packet;
  } seq_stat_t;

  // clamp a written count into 1..min(MaxChips, RowSlots)
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = v;
    if (r == '0) r = CountW'(1);
    if (r > CountW'(MaxChips)) r = CountW'(MaxChips);
    if (r > CountW'(RowSlots)) r = CountW'(RowSlots);
    return r;
  endfunction

  // packet for one chip of the chain
  function automatic logic [PacketW-1:0] make_packet(
    input logic [FuncW-1:0] func,
    input logic             target,
    input byte_t            addr,
    input byte_t            val,
    input byte_t            row
  );
    logic [PacketW-1:0] p;
    p = {NoopByte, NoopByte};
    case (func)
      FuncSingle: p = target ? {addr, val} : {NoopByte, NoopByte};
      FuncBcast:  p = {addr, val};
      FuncRow:    p = {addr, row};
      default:    p = {NoopByte, NoopByte};
    endcase
    return p;
  endfunction

endpackage

[rtl/led_driver_chain_serializer_top.sv]
// top level of the led driver chain serializer
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_chip_count_i
//  in      | in        | in_valid_i / in_ready_o   | func_i chip_i reg_addr_i value_i
//          |           |                           | row_byte0_i .. row_byte3_i
//  out     | out       | out_valid_o / out_ready_i | serial_bit_o frame_end_o
//
// a request is accepted, then its 16 * count bits (up to 64) go out one bit per
// cycle while the out channel is ready, through the single packet shift register; the
// next request is taken the cycle after the final bit is delivered
// dropped requests (func 3, or single-chip target beyond the chain) are accepted with no output
// reset: chip count back to 1, sequencer idle, no bits pending
// a stalled out channel holds the current bit; the sequencer simply waits
module led_driver_chain_serializer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lds_pkg::CountW-1:0]   cfg_chip_count_i,
  // request
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lds_pkg::FuncW-1:0]    func_i,
  input  logic [lds_pkg::ChipIdxW-1:0] chip_i,
  input  logic [lds_pkg::ByteW-1:0]    reg_addr_i,
  input  logic [lds_pkg::ByteW-1:0]    value_i,
  input  logic [lds_pkg::ByteW-1:0]    row_byte0_i,
  input  logic [lds_pkg::ByteW-1:0]    row_byte1_i,
  input  logic [lds_pkg::ByteW-1:0]    row_byte2_i,
  input  logic [lds_pkg::ByteW-1:0]    row_byte3_i,
  // serial bit stream
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         serial_bit_o,
  output logic                         frame_end_o
);

  logic [lds_pkg::CountW-1:0] chip_count_q, chip_count_d;
  lds_pkg::rows_t             rows;
  lds_pkg::shift_ctrl_t       ctrl;
  lds_pkg::seq_stat_t         stat;
  logic                       bit_last;
  logic                       msb;

  // config register, always ready; value is clamped on the way in
  assign cfg_ready_o  = 1'b1;
  assign chip_count_d = cfg_valid_i ? lds_pkg::clamp_count(cfg_chip_count_i)
                                    : chip_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_count_q <= lds_pkg::CountW'(1);
    end else begin
      chip_count_q <= chip_count_d;
    end
  end

  // row bytes indexed by chip number
  assign rows[0] = row_byte0_i;
  assign rows[1] = row_byte1_i;
  assign rows[2] = row_byte2_i;
  assign rows[3] = row_byte3_i;

  // walks packets from the farthest chip down to chip 0
  lds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (chip_count_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .chip_i      (chip_i),
    .addr_i      (reg_addr_i),
    .val_i       (value_i),
    .rows_i      (rows),
    .out_ready_i (out_ready_i),
    .bit_last_i  (bit_last),
    .ctrl_o      (ctrl),
    .stat_o      (stat)
  );

  // shared shift unit: msb first, one bit per delivered cycle
  lds_shifter u_shifter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .msb_o      (msb),
    .bit_last_o (bit_last)
  );

  // the shift register msb is the output register of the bit stream
  assign out_valid_o  = stat.busy;
  assign serial_bit_o = msb;
  // last bit of the packet for chip 0 closes the frame
  assign frame_end_o  = bit_last & stat.last_packet;

endmodule

[rtl/lds_shifter.sv]
// 16-bit packet shift register with bit counter
module lds_shifter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lds_pkg::shift_ctrl_t         ctrl_i,
  output logic                         msb_o,
  output logic                         bit_last_o
);

  logic [lds_pkg::PacketW-1:0] sr_q, sr_d;
  logic [lds_pkg::BitCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    sr_d  = sr_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      sr_d  = ctrl_i.packet;
      cnt_d = '0;
    end else if (ctrl_i.shift) begin
      sr_d  = {sr_q[lds_pkg::PacketW-2:0], 1'b0};
      cnt_d = cnt_q + lds_pkg::BitCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign msb_o      = sr_q[lds_pkg::PacketW-1];
  assign bit_last_o = (cnt_q == lds_pkg::BitCntW'(lds_pkg::PacketW - 1));

endmodule

[rtl/lds_seq.sv]
// request sequencer: walks chips from farthest to nearest and feeds the shifter
module lds_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [lds_pkg::CountW-1:0]        count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lds_pkg::FuncW-1:0]         func_i,
  input  logic [lds_pkg::ChipIdxW-1:0]      chip_i,
  input  lds_pkg::byte_t                    addr_i,
  input  lds_pkg::byte_t                    val_i,
  input  lds_pkg::rows_t                    rows_i,
  input  logic                              out_ready_i,
  input  logic                              bit_last_i,
  output lds_pkg::shift_ctrl_t              ctrl_o,
  output lds_pkg::seq_stat_t                stat_o
);

  lds_pkg::state_e state_q, state_d;
  logic [lds_pkg::FuncW-1:0]    func_q, func_d;
  logic [lds_pkg::ChipIdxW-1:0] chip_q, chip_d;
  logic [lds_pkg::ChipIdxW-1:0] idx_q, idx_d;
  lds_pkg::byte_t               addr_q, addr_d;
  lds_pkg::byte_t               val_q, val_d;
  lds_pkg::rows_t               rows_q, rows_d;

  logic [lds_pkg::ChipIdxW-1:0] first_idx;
  logic [lds_pkg::CountW-1:0]   count_m1;
  logic                         drop;

  assign count_m1  = count_i - lds_pkg::CountW'(1);
  assign first_idx = count_m1[lds_pkg::ChipIdxW-1:0];

  // unused code, or a single-chip target past the end of the chain
  assign drop = (func_i == lds_pkg::FuncW'(3)) ||
                ((func_i == lds_pkg::FuncSingle) &&
                 ({1'b0, chip_i} >= count_i));

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    chip_d  = chip_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    val_d   = val_q;
    rows_d  = rows_q;
    in_ready_o    = 1'b0;
    ctrl_o.load   = 1'b0;
    ctrl_o.shift  = 1'b0;
    ctrl_o.packet = '0;
    case (state_q)
      lds_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d = func_i;
          chip_d = chip_i;
          addr_d = addr_i;
          val_d  = val_i;
          rows_d = rows_i;
          idx_d  = first_idx;
          if (!drop) begin
            ctrl_o.load   = 1'b1;
            ctrl_o.packet = lds_pkg::make_packet(func_i, chip_i == first_idx,
                                                 addr_i, val_i, rows_i[first_idx]);
            state_d = lds_pkg::StShift;
          end
        end
      end
      lds_pkg::StShift: begin
        if (out_ready_i) begin
          if (bit_last_i) begin
            if (idx_q == '0) begin
              state_d = lds_pkg::StIdle;
            end else begin
              idx_d         = idx_q - lds_pkg::ChipIdxW'(1);
              ctrl_o.load   = 1'b1;
              ctrl_o.packet = lds_pkg::make_packet(func_q, chip_q == idx_d,
                                                   addr_q, val_q, rows_q[idx_d]);
            end
          end else begin
            ctrl_o.shift = 1'b1;
          end
        end
      end
      default: state_d = lds_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lds_pkg::StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    chip_q <= chip_d;
    addr_q <= addr_d;
    val_q  <= val_d;
    rows_q <= rows_d;
  end

  assign stat_o.busy        = (state_q == lds_pkg::StShift);
  assign stat_o.last_packet = (idx_q == '0);

endmodule

[bench/led_driver_chain_serializer_top_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the led driver chain serializer: frame predictor plus bit scoreboard
module led_driver_chain_serializer_top_tb;

  // func code that the block drops without output
  localparam logic [lds_pkg::FuncW-1:0] FuncUnused = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int WatchdogLimit = 2000;
  // a dropped request retires when it is accepted, give it some margin
  localparam int DropSettle = 4;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int HoldoffLen = 300;

  typedef enum logic [1:0] {
    RxAlways,
    RxRandom,
    RxPattern
  } rx_mode_e;

  // one register write request as offered on the in channel
  typedef struct packed {
    logic [lds_pkg::FuncW-1:0]    func;
    logic [lds_pkg::ChipIdxW-1:0] chip;
    lds_pkg::byte_t               addr;
    lds_pkg::byte_t               val;
    lds_pkg::rows_t               rows;
  } chain_req_t;

  // one bit of the serial line as the block should deliver it
  typedef struct packed {
    logic sbit;
    logic fend;
  } line_bit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lds_pkg::CountW-1:0]   cfg_count = '0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [lds_pkg::FuncW-1:0]    func_d = '0;
  logic [lds_pkg::ChipIdxW-1:0] chip_d = '0;
  lds_pkg::byte_t               addr_d = '0;
  lds_pkg::byte_t               val_d = '0;
  lds_pkg::byte_t               row0_d = '0;
  lds_pkg::byte_t               row1_d = '0;
  lds_pkg::byte_t               row2_d = '0;
  lds_pkg::byte_t               row3_d = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         serial_bit;
  logic                         frame_end;

  // predictor state: the chain length the block should be using right now
  logic [lds_pkg::CountW-1:0]   chain_len = lds_pkg::CountW'(1);
  // bits still owed by the block, oldest first
  line_bit_t                    frame_bits_q[$];

  int                  mismatch_cnt = 0;
  int                  frames_sent = 0;
  int                  idle_cycles = 0;

  // receiver control: mode and hold-off requests come from the tests,
  // the hold-off itself is counted inside the receiver process
  rx_mode_e            rx_mode = RxAlways;
  int                  holdoff_req = 0;
  int                  holdoff_seen = 0;
  int                  holdoff_left = 0;
  int                  pat_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  led_driver_chain_serializer_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_chip_count_i (cfg_count),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func_d),
    .chip_i           (chip_d),
    .reg_addr_i       (addr_d),
    .value_i          (val_d),
    .row_byte0_i      (row0_d),
    .row_byte1_i      (row1_d),
    .row_byte2_i      (row2_d),
    .row_byte3_i      (row3_d),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .serial_bit_o     (serial_bit),
    .frame_end_o      (frame_end)
  );

  // queue the frame one request should produce, return its length in bits
  // packets go out farthest chip first, each address byte then data byte, msb first
  function automatic int serialize_request(input chain_req_t r);
    logic [lds_pkg::PacketW-1:0] pkt;
    line_bit_t                   lb;
    int                          n;
    n = 0;
    // unused func code and a single-chip target past the chain yield nothing
    if (r.func == FuncUnused) return 0;
    if (r.func == lds_pkg::FuncSingle && r.chip >= chain_len) return 0;
    for (int c = int'(chain_len) - 1; c >= 0; c--) begin
      case (r.func)
        lds_pkg::FuncSingle: begin
          if (c == int'(r.chip)) pkt = {r.addr, r.val};
          else pkt = {lds_pkg::NoopByte, lds_pkg::NoopByte};
        end
        lds_pkg::FuncBcast:  pkt = {r.addr, r.val};
        lds_pkg::FuncRow:    pkt = {r.addr, r.rows[c]};
        default:             pkt = {lds_pkg::NoopByte, lds_pkg::NoopByte};
      endcase
      for (int b = lds_pkg::PacketW - 1; b >= 0; b--) begin
        lb.sbit = pkt[b];
        // chip 0's last bit closes the frame
        lb.fend = (c == 0 && b == 0);
        frame_bits_q.push_back(lb);
        n++;
      end
    end
    return n;
  endfunction

  // mostly random bytes, with the all-zero and all-one extremes mixed in
  function automatic lds_pkg::byte_t rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return lds_pkg::byte_t'($urandom);
    endcase
  endfunction

  // mostly well-formed requests (target inside the chain), some noise
  function automatic chain_req_t rand_request();
    chain_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.func = lds_pkg::FuncSingle;
    else if (pick < 60) r.func = lds_pkg::FuncBcast;
    else if (pick < 92) r.func = lds_pkg::FuncRow;
    else r.func = FuncUnused;
    if ($urandom_range(0, 4) != 0)
      r.chip = lds_pkg::ChipIdxW'($urandom_range(0, int'(chain_len) - 1));
    else
      r.chip = lds_pkg::ChipIdxW'($urandom);
    r.addr = rand_byte();
    r.val  = rand_byte();
    for (int i = 0; i < lds_pkg::RowSlots; i++) r.rows[i] = rand_byte();
    return r;
  endfunction

  function automatic chain_req_t make_request(
    input logic [lds_pkg::FuncW-1:0]    func,
    input logic [lds_pkg::ChipIdxW-1:0] chip,
    input lds_pkg::byte_t               addr,
    input lds_pkg::byte_t               val,
    input lds_pkg::rows_t               rows_in
  );
    chain_req_t r;
    r.func = func;
    r.chip = chip;
    r.addr = addr;
    r.val  = val;
    r.rows = rows_in;
    return r;
  endfunction

  // offer one request at the falling edge and hold it until accepted;
  // valid stays high on return so back-to-back requests need no gap
  task automatic send_request(input chain_req_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    func_d   <= r.func;
    chip_d   <= r.chip;
    addr_d   <= r.addr;
    val_d    <= r.val;
    row0_d   <= r.rows[0];
    row1_d   <= r.rows[1];
    row2_d   <= r.rows[2];
    row3_d   <= r.rows[3];
    do @(posedge clk); while (!in_ready);
    if (serialize_request(r) > 0) frames_sent++;
  endtask

  // sender gap of the given number of cycles
  task automatic hold_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending, let every owed bit arrive, then allow a dropped request to retire
  task automatic wait_drained();
    hold_sender(1);
    while (frame_bits_q.size() != 0) @(posedge clk);
    repeat (DropSettle) @(posedge clk);
  endtask

  // chip count write, only ever issued with the block idle
  task automatic write_chip_count(input logic [lds_pkg::CountW-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_count <= v;
    do @(posedge clk); while (!cfg_ready);
    // zero reads as one chip, anything past the chain limit is clipped
    if (v == '0) chain_len = lds_pkg::CountW'(1);
    else if (v > lds_pkg::CountW'(lds_pkg::MaxChips))
      chain_len = lds_pkg::CountW'(lds_pkg::MaxChips);
    else chain_len = v;
    if (chain_len > lds_pkg::CountW'(lds_pkg::RowSlots))
      chain_len = lds_pkg::CountW'(lds_pkg::RowSlots);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random requests in bursts until the given number of frames came out;
  // max_gap of zero means back-to-back with no sender idling
  task automatic run_bursts(input int frames_wanted, input int max_gap);
    int target;
    int burst;
    target = frames_sent + frames_wanted;
    while (frames_sent < target) begin
      burst = $urandom_range(1, 12);
      repeat (burst) send_request(rand_request());
      if (max_gap > 0) hold_sender($urandom_range(1, max_gap));
    end
  endtask

  // one-chip chain straight out of reset, including both kinds of dropped request
  task automatic test_reset_default();
    rx_mode = RxAlways;
    send_request(make_request(lds_pkg::FuncSingle, 2'd0, 8'hFF, 8'h00, '0));
    send_request(make_request(lds_pkg::FuncSingle, 2'd1, 8'h12, 8'h34, '0));
    send_request(make_request(lds_pkg::FuncSingle, 2'd3, 8'hFF, 8'hFF, '0));
    send_request(make_request(FuncUnused, 2'd0, 8'hA5, 8'h5A, '0));
    send_request(make_request(lds_pkg::FuncBcast, 2'd2, 8'h01, 8'h80, '0));
    send_request(make_request(lds_pkg::FuncRow, 2'd3, 8'h00, 8'hFF,
                              {8'h44, 8'h33, 8'h22, 8'hAA}));
  endtask

  // count writes beyond both ends of the range and at its top, each checked by a frame
  task automatic test_count_limits();
    rx_mode = RxRandom;
    write_chip_count(3'd0);
    send_request(make_request(lds_pkg::FuncBcast, 2'd0, 8'hC3, 8'h3C, '0));
    write_chip_count(3'd7);
    send_request(make_request(lds_pkg::FuncBcast, 2'd0, 8'h81, 8'h7E, '0));
    write_chip_count(3'd5);
    send_request(make_request(lds_pkg::FuncRow, 2'd0, 8'h0F, 8'h00,
                              {8'h80, 8'h01, 8'hF0, 8'h0F}));
    write_chip_count(3'd4);
    send_request(make_request(lds_pkg::FuncRow, 2'd1, 8'hFF, 8'h00,
                              {8'hFF, 8'h00, 8'hFF, 8'h00}));
  endtask

  // full four-chip chain: every target of single mode, extreme broadcasts, rows
  task automatic test_full_chain();
    rx_mode = RxPattern;
    for (int c = 0; c < lds_pkg::MaxChips; c++)
      send_request(make_request(lds_pkg::FuncSingle, lds_pkg::ChipIdxW'(c),
                                8'h10 + lds_pkg::byte_t'(c),
                                8'hE0 | lds_pkg::byte_t'(c), '0));
    send_request(make_request(lds_pkg::FuncBcast, 2'd3, 8'hFF, 8'hFF, '0));
    send_request(make_request(lds_pkg::FuncBcast, 2'd1, 8'h00, 8'h00, '0));
    send_request(make_request(lds_pkg::FuncRow, 2'd2, 8'h5A, 8'h00,
                              {8'hD4, 8'hC3, 8'hB2, 8'hA1}));
    send_request(make_request(FuncUnused, 2'd3, 8'hFF, 8'hFF, {4{8'hFF}}));
  endtask

  // receiver goes quiet for a long stretch while the sender keeps offering,
  // so the block fills and holds off its input
  task automatic test_holdoff();
    write_chip_count(3'd4);
    rx_mode = RxAlways;
    holdoff_req++;
    repeat (8) send_request(rand_request());
  endtask

  // sender stops mid-stream until every owed bit is out, then picks up again
  task automatic test_drain_pause();
    rx_mode = RxRandom;
    run_bursts(10, 6);
    wait_drained();
    run_bursts(10, 6);
  endtask

  // random phases over chain lengths, receiver modes and sender idling
  task automatic test_random();
    logic [lds_pkg::CountW-1:0] counts [8];
    counts = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3,
               lds_pkg::CountW'($urandom), lds_pkg::CountW'($urandom)};
    for (int p = 0; p < 8; p++) begin
      write_chip_count(counts[p]);
      rx_mode = rx_mode_e'(p % 3);
      run_bursts(34, (p % 2 == 0) ? 12 : 0);
    end
  endtask

  // receiver: hold-off first, otherwise the current stall mode
  always @(negedge clk) begin
    pat_cnt++;
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HoldoffLen;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RxAlways:  out_ready <= 1'b1;
        RxRandom:  out_ready <= ($urandom_range(0, 3) != 0);
        // odd period so stalls slide across every bit position of a packet
        RxPattern: out_ready <= ((pat_cnt % 11) < 7);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  // compare each delivered bit against the oldest one owed
  always @(posedge clk) begin : bit_scoreboard
    line_bit_t exp_bit;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bits_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 100)
          $display("%0t: unexpected bit, expected none, actual serial_bit=%b frame_end=%b",
                   $time, serial_bit, frame_end);
      end else begin
        exp_bit = frame_bits_q.pop_front();
        if (serial_bit !== exp_bit.sbit) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 100)
            $display("%0t: serial_bit expected %b actual %b", $time, exp_bit.sbit, serial_bit);
        end
        if (frame_end !== exp_bit.fend) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 100)
            $display("%0t: frame_end expected %b actual %b", $time, exp_bit.fend, frame_end);
        end
      end
    end
  end

  // hang detector: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_default();
    test_count_limits();
    test_full_chain();
    test_holdoff();
    test_drain_pause();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && frame_bits_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
